// ===== hdl/svw_pkg.sv =====
`default_nettype none

package svw_pkg;

	// Field and register widths.
	localparam int DATA_BITS = 32;
	localparam int MAX_TRUNC = 1023;
	localparam int TRUNC_W   = 10;
	localparam int RAD_W     = 24;
	localparam int CFG_W     = 24;

	// Coefficients are Q1.30 in a signed word.
	localparam int CW = 32;

	// Accumulator and shared multiplier sizes.
	localparam int ACC_W  = CW + DATA_BITS;
	localparam int LO_W   = ACC_W / 2;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int MUL_W  = ((LO_W + 1) > (CW + 1)) ? (LO_W + 1) : (CW + 1);
	localparam int PROD_W = 2 * MUL_W;

	// Register indexes of the configuration port.
	localparam logic CFG_TRUNC  = 1'b0;
	localparam logic CFG_RADIUS = 1'b1;

	localparam logic [TRUNC_W-1:0] TRUNC_RESET  = 10'd63;
	localparam logic [RAD_W-1:0]   RADIUS_RESET = 24'd6371000;

	// Operations of the coefficient unit.
	localparam logic OP_DD = 1'b0;
	localparam logic OP_SS = 1'b1;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] vor_re;
		logic signed [DATA_BITS-1:0] vor_im;
		logic signed [DATA_BITS-1:0] div_re;
		logic signed [DATA_BITS-1:0] div_im;
	} in_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] u_re;
		logic signed [DATA_BITS-1:0] u_im;
		logic signed [DATA_BITS-1:0] v_re;
		logic signed [DATA_BITS-1:0] v_im;
		logic [TRUNC_W-1:0]          order_m;
		logic [TRUNC_W-1:0]          degree_n;
		logic                        field_end;
	} out_t;

	typedef struct packed {
		logic               start;
		logic               op;
		logic [TRUNC_W-1:0] m;
		logic [TRUNC_W-1:0] n;
	} coef_req_t;

endpackage

`default_nettype wire

// ===== hdl/svw_mul.sv =====
`default_nettype none

// Shared signed multiplier with a registered product.
module svw_mul (
	input  wire logic                                   clk,
	input  wire logic signed [svw_pkg::MUL_W-1:0]       a,
	input  wire logic signed [svw_pkg::MUL_W-1:0]       b,
	output logic signed [svw_pkg::PROD_W-1:0]           p
);

	logic signed [svw_pkg::PROD_W-1:0] prod_s1;

	always_ff @(posedge clk) begin
		prod_s1 <= svw_pkg::PROD_W'(a) * svw_pkg::PROD_W'(b);
	end

	assign p = prod_s1;

endmodule

`default_nettype wire

// ===== hdl/svw_coef.sv =====
`default_nettype none

// Iterative coefficient unit: restoring divider, one quotient bit a cycle,
// followed for dd by an integer square root, one result bit a cycle.
module svw_coef (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire svw_pkg::coef_req_t               req,
	output logic                                  done,
	output logic signed [svw_pkg::CW-1:0]         coef
);

	localparam int NN_W  = 2 * svw_pkg::TRUNC_W;
	localparam int DVS_W = 2 * NN_W + 3;
	localparam int Q_W   = 2 * svw_pkg::CW - 2;
	localparam int CNT_W = $clog2(Q_W);

	localparam logic [2:0] C_IDLE  = 3'd0;
	localparam logic [2:0] C_PREP1 = 3'd1;
	localparam logic [2:0] C_PREP2 = 3'd2;
	localparam logic [2:0] C_DIV   = 3'd3;
	localparam logic [2:0] C_SQRT  = 3'd4;

	logic [2:0]                   st_q;
	logic                         done_q;
	logic                         op_q;
	logic                         zero_q;
	logic [svw_pkg::TRUNC_W-1:0]  m_q;
	logic [svw_pkg::TRUNC_W-1:0]  n_q;
	logic [NN_W-1:0]              nn_q;
	logic [NN_W-1:0]              mm_q;
	logic [DVS_W-1:0]             dvs_q;
	logic [DVS_W-1:0]             rem_q;
	logic [Q_W-1:0]               dnd_q;
	logic [Q_W-1:0]               quo_q;
	logic [Q_W-1:0]               res_q;
	logic [Q_W-1:0]               bit_q;
	logic [CNT_W-1:0]             cnt_q;
	logic signed [svw_pkg::CW-1:0] coef_q;

	logic [NN_W+1:0]   f4_w;
	logic [NN_W:0]     np_w;
	logic [2*NN_W+1:0] pd_w;
	logic [DVS_W:0]    r2_w;
	logic              ge_w;
	logic [Q_W-1:0]    quo_nx_w;
	logic [Q_W-1:0]    sum_w;
	logic              take_w;
	logic [Q_W-1:0]    res_nx_w;
	logic [Q_W-1:0]    rnd_w;

	always_comb begin
		f4_w     = ((NN_W + 2)'(nn_q) << 2) - (NN_W + 2)'(1);
		np_w     = (NN_W + 1)'(nn_q) + (NN_W + 1)'(n_q);
		pd_w     = (2 * NN_W + 2)'(f4_w) * (2 * NN_W + 2)'(nn_q);
		r2_w     = {rem_q, dnd_q[Q_W-1]};
		ge_w     = r2_w >= (DVS_W + 1)'(dvs_q);
		quo_nx_w = {quo_q[Q_W-2:0], ge_w};
		sum_w    = res_q + bit_q;
		take_w   = quo_q >= sum_w;
		res_nx_w = take_w ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		rnd_w    = (res_nx_w + Q_W'(1)) >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (req.start) begin
						st_q <= C_PREP1;
					end
				end
				C_PREP1: begin
					st_q <= C_PREP2;
				end
				C_PREP2: begin
					if (zero_q) begin
						done_q <= 1'b1;
						st_q   <= C_IDLE;
					end else begin
						st_q <= C_DIV;
					end
				end
				C_DIV: begin
					if (cnt_q == CNT_W'(Q_W - 1)) begin
						if (op_q == svw_pkg::OP_DD) begin
							st_q <= C_SQRT;
						end else begin
							done_q <= 1'b1;
							st_q   <= C_IDLE;
						end
					end
				end
				C_SQRT: begin
					if (bit_q == Q_W'(1)) begin
						done_q <= 1'b1;
						st_q   <= C_IDLE;
					end
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					m_q    <= req.m;
					n_q    <= req.n;
					zero_q <= (req.n == '0) ||
						((req.op == svw_pkg::OP_DD) && (req.n <= req.m));
				end
			end
			C_PREP1: begin
				nn_q <= NN_W'(n_q) * NN_W'(n_q);
				mm_q <= NN_W'(m_q) * NN_W'(m_q);
			end
			C_PREP2: begin
				quo_q <= '0;
				cnt_q <= '0;
				if (zero_q) begin
					coef_q <= '0;
				end
				if (op_q == svw_pkg::OP_DD) begin
					dvs_q <= DVS_W'(pd_w);
					rem_q <= DVS_W'(nn_q - mm_q);
					dnd_q <= '0;
				end else begin
					dvs_q <= DVS_W'({np_w, 1'b0});
					rem_q <= '0;
					dnd_q <= Q_W'({m_q, {(svw_pkg::CW - 1){1'b0}}}) + Q_W'(np_w);
				end
			end
			C_DIV: begin
				rem_q <= ge_w ? DVS_W'(r2_w - (DVS_W + 1)'(dvs_q)) : DVS_W'(r2_w);
				quo_q <= quo_nx_w;
				dnd_q <= dnd_q << 1;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(Q_W - 1)) begin
					res_q  <= '0;
					bit_q  <= Q_W'(1) << (Q_W - 2);
					coef_q <= -$signed(quo_nx_w[svw_pkg::CW-1:0]);
				end
			end
			C_SQRT: begin
				if (take_w) begin
					quo_q <= quo_q - sum_w;
				end
				res_q <= res_nx_w;
				bit_q <= bit_q >> 2;
				if (bit_q == Q_W'(1)) begin
					coef_q <= -$signed(rnd_w[svw_pkg::CW-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign coef = coef_q;

endmodule

`default_nettype wire

// ===== hdl/vorticity_divergence_to_wind_spectral.sv =====
`default_nettype none

// Channel   Direction  Handshake             Payload
// cfg       in         cfg_we                cfg_idx, cfg_data (truncation, radius)
// in        in         in_valid / in_stall   in_data  (vorticity, divergence pair)
// out       out        out_valid / out_stall out_data (U, V, m, n, field end)
//
// One input transaction yields zero to three output transactions. Each result
// first takes up to three coefficients from the shared divide/square-root unit,
// then computes its four components one after another on the shared multiplier.
// in_stall stays high from an accepted transaction that yields results until
// its last result has been taken; an output stall simply holds the result and
// the sequencer. Reset restores truncation 63, radius 6371000 and clears the
// position and window; writing truncation restarts the field at m = 0, n = 0.
module vorticity_divergence_to_wind_spectral (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_idx,
	input  wire logic [svw_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire svw_pkg::in_t                  in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output svw_pkg::out_t                      out_data
);

	localparam int TW  = svw_pkg::TRUNC_W;
	localparam int DB  = svw_pkg::DATA_BITS;
	localparam int FW  = svw_pkg::HI_W + svw_pkg::RAD_W + svw_pkg::LO_W + 2;
	localparam int SH  = 54;
	localparam int SW  = FW - SH;

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CREQ  = 4'd1;
	localparam logic [3:0] S_CWAIT = 4'd2;
	localparam logic [3:0] S_MUL   = 4'd3;
	localparam logic [3:0] S_ACC   = 4'd4;
	localparam logic [3:0] S_FLO   = 4'd5;
	localparam logic [3:0] S_FHI   = 4'd6;
	localparam logic [3:0] S_RND   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	// Sample sources held for one item.
	localparam logic [1:0] SEL_C  = 2'd0;
	localparam logic [1:0] SEL_W0 = 2'd1;
	localparam logic [1:0] SEL_W1 = 2'd2;

	// Terms of one result: lower neighbor, upper neighbor, same degree.
	localparam logic [1:0] T_LO  = 2'd0;
	localparam logic [1:0] T_UP  = 2'd1;
	localparam logic [1:0] T_MID = 2'd2;

	// Output components.
	localparam logic [1:0] K_UR = 2'd0;
	localparam logic [1:0] K_UI = 2'd1;
	localparam logic [1:0] K_VR = 2'd2;
	localparam logic [1:0] K_VI = 2'd3;

	localparam logic [FW-1:0] RND_C = FW'(1) << (SH - 1);
	localparam logic signed [SW-1:0] SMAX = SW'($signed({1'b0, {(DB - 1){1'b1}}}));
	localparam logic signed [SW-1:0] SMIN = SW'($signed({1'b1, {(DB - 1){1'b0}}}));

	typedef struct packed {
		logic [TW-1:0] m;
		logic [TW-1:0] n;
		logic          lo_en;
		logic [1:0]    lo_sel;
		logic          up_en;
		logic [1:0]    up_sel;
		logic          mid_en;
		logic [1:0]    mid_sel;
		logic          fend;
	} desc_t;

	// Control and configuration state.
	logic [3:0]                 st_q;
	logic [1:0]                 rcnt_q;
	logic [1:0]                 ridx_q;
	logic [1:0]                 j_q;
	logic [1:0]                 k_q;
	logic [TW-1:0]              trunc_q;
	logic [svw_pkg::RAD_W-1:0]  radius_q;
	logic [TW-1:0]              cur_m_q;
	logic [TW-1:0]              cur_n_q;
	svw_pkg::in_t               w0_q;
	svw_pkg::in_t               w1_q;

	// Working registers of the current item.
	svw_pkg::in_t               smp_q [3];
	desc_t                      desc_q [3];
	logic signed [svw_pkg::CW-1:0] coef_a_q;
	logic signed [svw_pkg::CW-1:0] coef_b_q;
	logic signed [svw_pkg::CW-1:0] coef_s_q;
	logic signed [svw_pkg::ACC_W-1:0] acc_q;
	logic [svw_pkg::LO_W+svw_pkg::RAD_W-1:0] plo_q;
	svw_pkg::out_t              out_q;

	// Accept-side decode.
	logic          in_acc_w;
	logic [TW-1:0] t_w;
	logic [TW-1:0] last_w;
	logic          pos_ok_w;
	logic [TW-1:0] m_w;
	logic [TW-1:0] n_w;
	svw_pkg::in_t  w0_w;
	svw_pkg::in_t  w1_w;
	desc_t         d_w [3];
	logic [1:0]    cnt_w;

	// Sequencer datapath.
	desc_t                         cd_w;
	logic                          en_w;
	logic [1:0]                    sel_w;
	logic signed [svw_pkg::CW-1:0] coef_w;
	svw_pkg::in_t                  smp_w;
	logic signed [DB-1:0]          fld_w;
	logic                          neg_w;
	svw_pkg::coef_req_t            req_w;
	logic                          cdone_w;
	logic signed [svw_pkg::CW-1:0] cval_w;
	logic signed [svw_pkg::MUL_W-1:0]  ma_w;
	logic signed [svw_pkg::MUL_W-1:0]  mb_w;
	logic signed [svw_pkg::PROD_W-1:0] prod_w;
	logic signed [FW-1:0]          full_w;
	logic [FW-1:0]                 rnd_w;
	logic signed [SW-1:0]          shr_w;
	logic signed [DB-1:0]          dv_w;

	svw_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_w),
		.done   (cdone_w),
		.coef   (cval_w)
	);

	svw_mul u_mul (
		.clk (clk),
		.a   (ma_w),
		.b   (mb_w),
		.p   (prod_w)
	);

	assign in_stall  = (st_q != S_IDLE);
	assign in_acc_w  = in_valid && !in_stall;
	assign out_valid = (st_q == S_OUT);
	assign out_data  = out_q;

	// Position check and result list for an incoming transaction.
	always_comb begin
		if (trunc_q == '0) begin
			t_w = TW'(1);
		end else if ({1'b0, trunc_q} > (TW + 1)'(svw_pkg::MAX_TRUNC)) begin
			t_w = TW'(svw_pkg::MAX_TRUNC);
		end else begin
			t_w = trunc_q;
		end
		last_w   = t_w - TW'(1);
		pos_ok_w = (cur_m_q <= last_w) && (cur_n_q <= last_w) && (cur_n_q >= cur_m_q);
		m_w      = pos_ok_w ? cur_m_q : '0;
		n_w      = pos_ok_w ? cur_n_q : '0;
		w0_w     = pos_ok_w ? w0_q : '0;
		w1_w     = pos_ok_w ? w1_q : '0;

		for (int i = 0; i < 3; i++) begin
			d_w[i] = '0;
		end
		cnt_w = 2'd0;

		if ((n_w > m_w) && (n_w != last_w)) begin
			// Interior input: the result one degree below it.
			d_w[0].m       = m_w;
			d_w[0].n       = n_w - TW'(1);
			d_w[0].lo_en   = (n_w - TW'(1)) > m_w;
			d_w[0].lo_sel  = SEL_W1;
			d_w[0].mid_en  = 1'b1;
			d_w[0].mid_sel = SEL_W0;
			d_w[0].up_en   = 1'b1;
			d_w[0].up_sel  = SEL_C;
			cnt_w          = 2'd1;
		end else if (n_w > m_w) begin
			// Last input of a row: three results close the row.
			d_w[0].m       = m_w;
			d_w[0].n       = n_w - TW'(1);
			d_w[0].lo_en   = (n_w - TW'(1)) > m_w;
			d_w[0].lo_sel  = SEL_W1;
			d_w[0].mid_en  = 1'b1;
			d_w[0].mid_sel = SEL_W0;
			d_w[0].up_en   = 1'b1;
			d_w[0].up_sel  = SEL_C;
			d_w[1].m       = m_w;
			d_w[1].n       = last_w;
			d_w[1].lo_en   = 1'b1;
			d_w[1].lo_sel  = SEL_W0;
			d_w[1].mid_en  = 1'b1;
			d_w[1].mid_sel = SEL_C;
			d_w[2].m       = m_w;
			d_w[2].n       = t_w;
			d_w[2].lo_en   = 1'b1;
			d_w[2].lo_sel  = SEL_C;
			cnt_w          = 2'd3;
		end else if (n_w == last_w) begin
			// Single-entry last row: its two results and the zero corner.
			d_w[0].m       = m_w;
			d_w[0].n       = last_w;
			d_w[0].mid_en  = 1'b1;
			d_w[0].mid_sel = SEL_C;
			d_w[1].m       = m_w;
			d_w[1].n       = t_w;
			d_w[1].lo_en   = 1'b1;
			d_w[1].lo_sel  = SEL_C;
			d_w[2].m       = t_w;
			d_w[2].n       = t_w;
			d_w[2].fend    = 1'b1;
			cnt_w          = 2'd3;
		end
	end

	// Term decode for the current result, term and component.
	always_comb begin
		cd_w = desc_q[ridx_q];
		case (j_q)
			T_LO: begin
				en_w   = cd_w.lo_en;
				sel_w  = cd_w.lo_sel;
				coef_w = coef_a_q;
			end
			T_UP: begin
				en_w   = cd_w.up_en;
				sel_w  = cd_w.up_sel;
				coef_w = coef_b_q;
			end
			default: begin
				en_w   = cd_w.mid_en;
				sel_w  = cd_w.mid_sel;
				coef_w = coef_s_q;
			end
		endcase

		case (sel_w)
			SEL_W0:  smp_w = smp_q[1];
			SEL_W1:  smp_w = smp_q[2];
			default: smp_w = smp_q[0];
		endcase

		// The same-degree term is the imaginary unit times ss times the sample.
		case ({j_q, k_q})
			{T_LO, K_UR}:  begin fld_w = smp_w.vor_re; neg_w = 1'b0; end
			{T_LO, K_UI}:  begin fld_w = smp_w.vor_im; neg_w = 1'b0; end
			{T_LO, K_VR}:  begin fld_w = smp_w.div_re; neg_w = 1'b1; end
			{T_LO, K_VI}:  begin fld_w = smp_w.div_im; neg_w = 1'b1; end
			{T_UP, K_UR}:  begin fld_w = smp_w.vor_re; neg_w = 1'b1; end
			{T_UP, K_UI}:  begin fld_w = smp_w.vor_im; neg_w = 1'b1; end
			{T_UP, K_VR}:  begin fld_w = smp_w.div_re; neg_w = 1'b0; end
			{T_UP, K_VI}:  begin fld_w = smp_w.div_im; neg_w = 1'b0; end
			{T_MID, K_UR}: begin fld_w = smp_w.div_im; neg_w = 1'b1; end
			{T_MID, K_UI}: begin fld_w = smp_w.div_re; neg_w = 1'b0; end
			{T_MID, K_VR}: begin fld_w = smp_w.vor_im; neg_w = 1'b1; end
			{T_MID, K_VI}: begin fld_w = smp_w.vor_re; neg_w = 1'b0; end
			default:       begin fld_w = '0;           neg_w = 1'b0; end
		endcase

		// Coefficient request: dd at n for the lower term, dd at n+1 for the
		// upper term, ss at n for the same-degree term.
		req_w.start = (st_q == S_CREQ) && en_w;
		req_w.op    = (j_q == T_MID) ? svw_pkg::OP_SS : svw_pkg::OP_DD;
		req_w.m     = cd_w.m;
		req_w.n     = (j_q == T_UP) ? (cd_w.n + TW'(1)) : cd_w.n;
	end

	// Multiplier operands: terms, then the sum times the radius in two halves.
	always_comb begin
		case (st_q)
			S_MUL: begin
				ma_w = svw_pkg::MUL_W'(coef_w);
				mb_w = svw_pkg::MUL_W'(fld_w);
			end
			S_FLO: begin
				ma_w = $signed(svw_pkg::MUL_W'(radius_q));
				mb_w = $signed(svw_pkg::MUL_W'(acc_q[svw_pkg::LO_W-1:0]));
			end
			S_FHI: begin
				ma_w = $signed(svw_pkg::MUL_W'(radius_q));
				mb_w = svw_pkg::MUL_W'($signed(acc_q[svw_pkg::ACC_W-1:svw_pkg::LO_W]));
			end
			default: begin
				ma_w = '0;
				mb_w = '0;
			end
		endcase
	end

	// Round half up to 2^-16 and saturate.
	always_comb begin
		full_w = (FW'(prod_w) <<< svw_pkg::LO_W) + $signed(FW'({1'b0, plo_q}));
		rnd_w  = full_w + RND_C;
		shr_w  = rnd_w[FW-1:SH];
		if (shr_w > SMAX) begin
			dv_w = SMAX[DB-1:0];
		end else if (shr_w < SMIN) begin
			dv_w = SMIN[DB-1:0];
		end else begin
			dv_w = shr_w[DB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			rcnt_q   <= '0;
			ridx_q   <= '0;
			j_q      <= '0;
			k_q      <= '0;
			trunc_q  <= svw_pkg::TRUNC_RESET;
			radius_q <= svw_pkg::RADIUS_RESET;
			cur_m_q  <= '0;
			cur_n_q  <= '0;
			w0_q     <= '0;
			w1_q     <= '0;
		end else begin
			// Position and window advance as soon as the transaction is taken.
			if (in_acc_w) begin
				if (n_w == last_w) begin
					w0_q <= '0;
					w1_q <= '0;
					if (m_w == last_w) begin
						cur_m_q <= '0;
						cur_n_q <= '0;
					end else begin
						cur_m_q <= m_w + TW'(1);
						cur_n_q <= m_w + TW'(1);
					end
				end else begin
					w1_q    <= w0_w;
					w0_q    <= in_data;
					cur_m_q <= m_w;
					cur_n_q <= n_w + TW'(1);
				end
			end

			if (cfg_we) begin
				if (cfg_idx == svw_pkg::CFG_TRUNC) begin
					trunc_q <= cfg_data[TW-1:0];
					cur_m_q <= '0;
					cur_n_q <= '0;
					w0_q    <= '0;
					w1_q    <= '0;
				end else begin
					radius_q <= cfg_data[svw_pkg::RAD_W-1:0];
				end
			end

			case (st_q)
				S_IDLE: begin
					if (in_acc_w && (cnt_w != 2'd0)) begin
						rcnt_q <= cnt_w;
						ridx_q <= '0;
						j_q    <= T_LO;
						st_q   <= S_CREQ;
					end
				end
				S_CREQ: begin
					if (en_w) begin
						st_q <= S_CWAIT;
					end else if (j_q == T_MID) begin
						j_q  <= T_LO;
						k_q  <= K_UR;
						st_q <= S_MUL;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_CWAIT: begin
					if (cdone_w) begin
						if (j_q == T_MID) begin
							j_q  <= T_LO;
							k_q  <= K_UR;
							st_q <= S_MUL;
						end else begin
							j_q  <= j_q + 2'd1;
							st_q <= S_CREQ;
						end
					end
				end
				S_MUL: begin
					if (en_w) begin
						st_q <= S_ACC;
					end else if (j_q == T_MID) begin
						j_q  <= T_LO;
						st_q <= S_FLO;
					end else begin
						j_q <= j_q + 2'd1;
					end
				end
				S_ACC: begin
					if (j_q == T_MID) begin
						j_q  <= T_LO;
						st_q <= S_FLO;
					end else begin
						j_q  <= j_q + 2'd1;
						st_q <= S_MUL;
					end
				end
				S_FLO: begin
					st_q <= S_FHI;
				end
				S_FHI: begin
					st_q <= S_RND;
				end
				S_RND: begin
					if (k_q == K_VI) begin
						st_q <= S_OUT;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						if ((ridx_q + 2'd1) == rcnt_q) begin
							st_q <= S_IDLE;
						end else begin
							ridx_q <= ridx_q + 2'd1;
							j_q    <= T_LO;
							st_q   <= S_CREQ;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc_w) begin
			smp_q[0] <= in_data;
			smp_q[1] <= w0_w;
			smp_q[2] <= w1_w;
			for (int i = 0; i < 3; i++) begin
				desc_q[i] <= d_w[i];
			end
		end

		if ((st_q == S_CWAIT) && cdone_w) begin
			case (j_q)
				T_LO:    coef_a_q <= cval_w;
				T_UP:    coef_b_q <= cval_w;
				default: coef_s_q <= cval_w;
			endcase
		end

		if ((st_q == S_CREQ) || (st_q == S_CWAIT) || (st_q == S_RND)) begin
			acc_q <= '0;
		end else if (st_q == S_ACC) begin
			if (neg_w) begin
				acc_q <= acc_q - $signed(prod_w[svw_pkg::ACC_W-1:0]);
			end else begin
				acc_q <= acc_q + $signed(prod_w[svw_pkg::ACC_W-1:0]);
			end
		end

		if (st_q == S_FHI) begin
			plo_q <= prod_w[svw_pkg::LO_W+svw_pkg::RAD_W-1:0];
		end

		if (st_q == S_RND) begin
			case (k_q)
				K_UR:    out_q.u_re <= dv_w;
				K_UI:    out_q.u_im <= dv_w;
				K_VR:    out_q.v_re <= dv_w;
				default: out_q.v_im <= dv_w;
			endcase
			out_q.order_m   <= cd_w.m;
			out_q.degree_n  <= cd_w.n;
			out_q.field_end <= cd_w.fend;
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/vorticity_divergence_to_wind_spectral_tb.sv =====
`timescale 1ns / 100ps

module vorticity_divergence_to_wind_spectral_tb;
	import svw_pkg::*;

	typedef logic signed [127:0] wide_t;

	// Results pass through the coefficient unit and the multiplier, so the settle
	// time after an input with no result and the stuck limit are generous.
	localparam int SETTLE_CYCLES = 1500;
	localparam int STUCK_LIMIT   = 20000;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	logic  cfg_idx;
	logic  [CFG_W-1:0] cfg_data;
	logic  in_valid;
	logic  in_stall;
	in_t   in_data;
	logic  out_valid;
	logic  out_stall;
	out_t  out_data;

	vorticity_divergence_to_wind_spectral i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	// Shadow copy of the block's registers and position used by the predictor.
	logic [TRUNC_W-1:0] shadow_trunc;
	logic [RAD_W-1:0]   shadow_radius;
	int unsigned        pos_m;
	int unsigned        pos_n;
	in_t                win_near;   // previous input of the current row
	in_t                win_far;    // the one before that

	out_t wind_expected[$];
	int   mismatches;
	int   items_sent;
	int   hold_cycles;     // one-shot long stall request for the receiver
	bit   no_idle;         // when set, neither side inserts gaps

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction of the wind coefficients.
	// ------------------------------------------------------------------

	// dd(m,n) in Q1.30: the square root of num/den scaled by 2^62 gives twice
	// the wanted magnitude, so halve it with rounding.
	function automatic longint dd_coef(longint unsigned m, longint unsigned n);
		longint unsigned num, den, q, root, probe;
		logic [127:0] scaled;
		if (n == 0 || n <= m)
			return 0;
		num = n * n - m * m;
		den = (4 * n * n - 1) * n * n;
		scaled = ({64'd0, num} << 62) / {64'd0, den};
		q = scaled[63:0];
		root = 0;
		probe = 64'd1 << 62;
		while (probe > q)
			probe >>= 2;
		while (probe != 0) begin
			if (q >= root + probe) begin
				q -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return -longint'((root + 1) >> 1);
	endfunction

	function automatic longint ss_coef(longint unsigned m, longint unsigned n);
		longint unsigned den;
		if (n == 0)
			return 0;
		den = n * (n + 1);
		return -longint'(((m << 31) + den) / (2 * den));
	endfunction

	function automatic wide_t mul_term(longint c, logic signed [DATA_BITS-1:0] x);
		return wide_t'(c) * wide_t'(x);
	endfunction

	// Scale by the radius, round to LSB 2^-16 with ties upward, saturate.
	function automatic logic [DATA_BITS-1:0] scale_round_sat(wide_t acc);
		wide_t p;
		p = acc * $signed({104'd0, shadow_radius});
		p = p + (wide_t'(1) <<< 53);
		p = p >>> 54;
		if (p > wide_t'(32'sh7fffffff))
			return 32'h7fffffff;
		if (p < -wide_t'(64'sh80000000))
			return 32'h80000000;
		return p[DATA_BITS-1:0];
	endfunction

	function automatic out_t wind_coef(int unsigned m, int unsigned n,
		bit has_lo, in_t lo, bit has_mid, in_t mid, bit has_up, in_t up, bit fin);
		wide_t ur, ui, vr, vi;
		longint a, b, s;
		out_t r;
		ur = 0; ui = 0; vr = 0; vi = 0;
		if (has_lo) begin
			a = dd_coef(m, n);
			ur += mul_term(a, lo.vor_re);
			ui += mul_term(a, lo.vor_im);
			vr += mul_term(-a, lo.div_re);
			vi += mul_term(-a, lo.div_im);
		end
		if (has_up) begin
			b = dd_coef(m, n + 1);
			ur += mul_term(-b, up.vor_re);
			ui += mul_term(-b, up.vor_im);
			vr += mul_term(b, up.div_re);
			vi += mul_term(b, up.div_im);
		end
		if (has_mid) begin
			s = ss_coef(m, n);
			ur += mul_term(-s, mid.div_im);
			ui += mul_term(s, mid.div_re);
			vr += mul_term(-s, mid.vor_im);
			vi += mul_term(s, mid.vor_re);
		end
		r.u_re      = scale_round_sat(ur);
		r.u_im      = scale_round_sat(ui);
		r.v_re      = scale_round_sat(vr);
		r.v_im      = scale_round_sat(vi);
		r.order_m   = m[TRUNC_W-1:0];
		r.degree_n  = n[TRUNC_W-1:0];
		r.field_end = fin;
		return r;
	endfunction

	function automatic void restart_field();
		pos_m = 0;
		pos_n = 0;
		win_near = '0;
		win_far  = '0;
	endfunction

	// Advance the shadow position by one accepted input and queue its results.
	function automatic void predict_wind(in_t c);
		int unsigned t, last_n, m, n;
		t = (shadow_trunc == 0) ? 1 : shadow_trunc;
		last_n = t - 1;
		if (pos_m > last_n || pos_n > last_n || pos_n < pos_m)
			restart_field();
		m = pos_m;
		n = pos_n;
		if (n > m)
			wind_expected.push_back(wind_coef(m, n - 1, (n - 1 > m), win_far,
				1'b1, win_near, 1'b1, c, 1'b0));
		if (n == last_n) begin
			wind_expected.push_back(wind_coef(m, last_n, (last_n > m), win_near,
				1'b1, c, 1'b0, c, 1'b0));
			wind_expected.push_back(wind_coef(m, t, 1'b1, c, 1'b0, c, 1'b0, c, 1'b0));
			if (m == last_n) begin
				// The last input closes the field with the all-zero (T,T) entry.
				wind_expected.push_back(wind_coef(t, t, 1'b0, c, 1'b0, c, 1'b0, c, 1'b1));
				restart_field();
			end else begin
				restart_field();
				pos_m = m + 1;
				pos_n = m + 1;
			end
		end else begin
			win_far  = win_near;
			win_near = c;
			pos_n    = n + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Sender side and configuration writes.
	// ------------------------------------------------------------------

	function automatic logic [DATA_BITS-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00000000;
			3: return 32'hffffffff;
			default: return $urandom();
		endcase
	endfunction

	function automatic in_t random_sample();
		in_t d;
		d.vor_re = pick_word();
		d.vor_im = pick_word();
		d.div_re = pick_word();
		d.div_im = pick_word();
		return d;
	endfunction

	// Offers one transaction, optionally after a random gap, and waits for it
	// to be taken. in_valid stays high afterwards so back-to-back items are
	// possible; whoever needs an idle input lowers it.
	task automatic send_sample(in_t d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= d;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_wind(d);
		items_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (wind_expected.size() == 0);
		// An input that yields no result may still be in flight.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
		wait_idle();
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TRUNC) begin
			shadow_trunc = value[TRUNC_W-1:0];
			restart_field();
		end else begin
			shadow_radius = value[RAD_W-1:0];
		end
	endtask

	task automatic send_field(int count);
		repeat (count) send_sample(random_sample());
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Reset values: truncation 63 and the Earth radius, first row partially.
	task automatic test_reset_values();
		send_field(6);
	endtask

	// Extremes of the data with the largest radius at T = 2, where the
	// coefficients are largest and the sums saturate both ways.
	task automatic test_extremes();
		in_t d;
		write_reg(CFG_RADIUS, 24'hffffff);
		write_reg(CFG_TRUNC, 24'd2);
		d = {32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff};
		repeat (3) send_sample(d);
		d = {32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000};
		repeat (3) send_sample(d);
		d = '1;
		repeat (3) send_sample(d);
		// Truncation zero acts as one: every input closes a whole field.
		write_reg(CFG_TRUNC, 24'd0);
		send_field(2);
		write_reg(CFG_TRUNC, 24'd1);
		send_field(1);
		// Zero radius forces all results to zero; radius one is tiny.
		write_reg(CFG_RADIUS, 24'd0);
		write_reg(CFG_TRUNC, 24'd3);
		send_field(6);
		write_reg(CFG_RADIUS, 24'd1);
		send_field(3);
	endtask

	// The largest truncation, only the start of the first row since a full
	// field would be far too long.
	task automatic test_max_truncation();
		write_reg(CFG_RADIUS, 24'd6371000);
		write_reg(CFG_TRUNC, 24'd1023);
		send_field(3);
		write_reg(CFG_TRUNC, 24'h3ff);
		send_field(2);
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		write_reg(CFG_TRUNC, 24'd3);
		hold_cycles = 400;
		send_field(6);
		// Sender pauses until every pending result has been delivered.
		in_valid <= 1'b0;
		@(posedge clk);
		wait (wind_expected.size() == 0);
		send_field(6);
	endtask

	// Mostly complete fields at small truncations with random content; some
	// fields are cut short by a truncation write, which restarts the field.
	task automatic test_random_fields();
		int t, count;
		while (items_sent < 360) begin
			case ($urandom_range(0, 3))
				0: write_reg(CFG_RADIUS, 24'hffffff);
				1: write_reg(CFG_RADIUS, $urandom_range(1, 24'hffffff));
				default: write_reg(CFG_RADIUS, $urandom_range(1000, 8000000));
			endcase
			t = $urandom_range(1, 6);
			write_reg(CFG_TRUNC, t);
			no_idle = ($urandom_range(0, 4) == 0);
			count = t * (t + 1) / 2;
			if ($urandom_range(0, 4) == 0)
				count = $urandom_range(1, count);
			else
				count = count * $urandom_range(1, 2);
			send_field(count);
			no_idle = 1'b0;
		end
	endtask

	// Receiver: a random stall before each result, with the long hold-off
	// taken once when a test asks for it.
	initial begin
		int n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = no_idle ? 0 : $urandom_range(0, 5);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Checks every delivered result against the oldest pending prediction.
	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (wind_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result m=%0d n=%0d",
						out_data.order_m, out_data.degree_n);
			end else begin
				want = wind_expected.pop_front();
				if (out_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: m=%0d n=%0d exp u=(%h,%h) v=(%h,%h) end=%b, got m=%0d n=%0d u=(%h,%h) v=(%h,%h) end=%b",
							want.order_m, want.degree_n, want.u_re, want.u_im,
							want.v_re, want.v_im, want.field_end,
							out_data.order_m, out_data.degree_n, out_data.u_re,
							out_data.u_im, out_data.v_re, out_data.v_im,
							out_data.field_end);
				end
			end
		end
	end

	// Ends the run if no transaction moves on either channel for too long.
	always @(posedge clk) begin
		int stuck;
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_idx    = CFG_TRUNC;
		cfg_data   = '0;
		in_valid   = 1'b0;
		in_data    = '0;
		mismatches = 0;
		items_sent = 0;
		hold_cycles = 0;
		no_idle    = 1'b0;
		shadow_trunc  = TRUNC_RESET;
		shadow_radius = RADIUS_RESET;
		restart_field();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_extremes();
		test_max_truncation();
		test_backpressure();
		test_random_fields();

		wait_idle();
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/svw_pkg.sv
hdl/svw_mul.sv
hdl/svw_coef.sv
hdl/vorticity_divergence_to_wind_spectral.sv
tb/sv/vorticity_divergence_to_wind_spectral_tb.sv
